### src/ccl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types and constants of the console command line recogniser.
// ----------------------------------------------------------------------------
package ccl_pkg;

    // Control characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Command codes on the result stream
    localparam logic [1:0] CODE_AT      = 2'd0;
    localparam logic [1:0] CODE_CHECK   = 2'd1;
    localparam logic [1:0] CODE_HELP    = 2'd2;
    localparam logic [1:0] CODE_UNKNOWN = 2'd3;

    // Idle tick counter
    localparam int unsigned IDLE_W = 10;
    localparam logic [IDLE_W-1:0] IDLE_MAX       = 10'd1023;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 10'd150;

    // Command words: AT, CHECK, HELP, ?
    localparam int unsigned WORD_CNT = 4;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned POS_N    = 8;
    localparam logic [POS_W-1:0] POS_MAX = 3'd7;

    localparam int unsigned W_AT    = 0;
    localparam int unsigned W_CHECK = 1;
    localparam int unsigned W_HELP  = 2;
    localparam int unsigned W_QUERY = 3;

    localparam logic [7:0] WORD_TXT [WORD_CNT][POS_N] = '{
        '{8'h41, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h48, 8'h45, 8'h43, 8'h4B, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h45, 8'h4C, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [POS_W-1:0] WORD_LEN [WORD_CNT] = '{3'd2, 3'd5, 3'd4, 3'd1};

    // Dispatch sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Character classification from the compare unit
    typedef struct packed {
        logic                zero;
        logic                blank;
        logic [WORD_CNT-1:0] hit;
    } t_cmp_res;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h61:8'h7A]}) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/ccl_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccl_line_mem
// Line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ccl_line_mem #(
    parameter int unsigned DEPTH  = 95,
    parameter int unsigned ADDR_W = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### src/ccl_cmp_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccl_cmp_unit
// Shared character compare: classifies one stored character and matches it,
// case folded, against each command word at a given position.
// ----------------------------------------------------------------------------
module ccl_cmp_unit (
    input  wire logic [7:0]              i_char,
    input  wire logic [ccl_pkg::POS_W-1:0] i_pos,
    output ccl_pkg::t_cmp_res            o_res
);
    import ccl_pkg::*;

    logic [7:0] w_up;

    assign w_up = fold_upper(i_char);

    always_comb begin
        o_res.zero  = (i_char == CH_NUL);
        o_res.blank = (i_char == CH_SPACE) || (i_char == CH_TAB);
        for (int w = 0; w < WORD_CNT; w++) begin
            o_res.hit[w] = (i_pos < WORD_LEN[w]) && (w_up == WORD_TXT[w][i_pos]);
        end
    end

endmodule
`default_nettype wire

### src/console_command_line_recognizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A byte or a tick that does not dispatch is taken with s_axis_tready left high.
// A dispatch holds s_axis_tready low through the registered line-store scan and the
// decide state, longer while an earlier result still waits on m_axis; the result
// appears on the edge where tready returns.
// The input takes one transfer a cycle between dispatches and no new item during one.
// Reset (i_rst_n low, synchronous): line empty, idle 0, heartbeat on, limit 150, no result.
// ----------------------------------------------------------------------------
// console_command_line_recognizer_core
// Collects console bytes into a line store and, on CR/LF or idle timeout,
// walks the line through a shared compare unit to recognise AT, CHECK, HELP/?.
// ----------------------------------------------------------------------------
module console_command_line_recognizer_core #(
    parameter int unsigned LINE_CAPACITY = 96
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration: idle_flush_ticks
    input  wire logic       i_cfg_wr_en,
    input  wire logic [9:0] i_cfg_wr_data,
    // Input stream
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [0:0] s_axis_tuser,   // [0] func (0 byte, 1 tick)
    // Result stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata    // [1:0] command, [2] heartbeat_on,
                                            // [3] by_timeout, [7:4] zero
);
    import ccl_pkg::*;

    localparam int unsigned DEPTH  = LINE_CAPACITY - 1;
    localparam int unsigned LEN_W  = $clog2(LINE_CAPACITY);
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_CAPACITY - 1);

    // ---------------------------------------------------------------- state
    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_len, n_len;          // stored characters
    logic [IDLE_W-1:0]   r_idle, n_idle;        // ticks since last byte
    logic [IDLE_W-1:0]   r_limit, n_limit;      // idle_flush_ticks
    logic                r_hb, n_hb;            // heartbeat flag
    logic                r_timeout, n_timeout;  // current dispatch cause
    // scan
    logic [LEN_W-1:0]    r_rd_idx, n_rd_idx;    // next read address
    logic                r_dv, n_dv;            // read data valid this cycle
    logic                r_cut, n_cut;          // zero byte seen: rest ignored
    logic                r_any, n_any;          // first non-blank found
    logic                r_gap, n_gap;          // blank seen after text start
    logic [POS_W-1:0]    r_pos, n_pos;          // next position from text start
    logic [POS_W-1:0]    r_last, n_last;        // trimmed length (saturating)
    logic [WORD_CNT-1:0] r_ok, n_ok;            // word still matching
    // result register
    logic                r_m_valid, n_m_valid;
    logic [3:0]          r_m_data, n_m_data;

    // ------------------------------------------------------------ decoding
    logic                s_xfer, is_tick, is_term, flush;
    logic [IDLE_W-1:0]   idle_inc;
    logic                wr_en, rd_en, out_load, out_free;
    logic [7:0]          rd_data;
    logic [POS_W-1:0]    cmp_pos;
    t_cmp_res            cmp;
    logic [WORD_CNT-1:0] match;
    logic [1:0]          cmd;

    assign s_xfer   = s_axis_tvalid && s_axis_tready;
    assign is_tick  = s_axis_tuser[0];
    assign is_term  = (s_axis_tdata == CH_CR) || (s_axis_tdata == CH_LF);
    assign idle_inc = (r_idle == IDLE_MAX) ? r_idle : r_idle + 10'd1;
    // a non-empty line is dispatched by a terminator or by the idle limit
    assign flush    = s_xfer && (r_len != '0)
                      && (is_tick ? (idle_inc >= r_limit) : is_term);
    assign out_free = !r_m_valid || m_axis_tready;

    // --------------------------------------------------------- line store
    ccl_line_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_len[ADDR_W-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // ----------------------------------------------------- compare unit
    assign cmp_pos = r_any ? r_pos : '0;

    ccl_cmp_unit u_cmp (
        .i_char (rd_data),
        .i_pos  (cmp_pos),
        .o_res  (cmp)
    );

    // trimmed text must cover every word position, all non-blank
    always_comb begin
        for (int w = 0; w < WORD_CNT; w++) begin
            match[w] = r_ok[w] && (r_last == WORD_LEN[w]);
        end
        if (match[W_AT]) begin
            cmd = CODE_AT;
        end else if (match[W_CHECK]) begin
            cmd = CODE_CHECK;
        end else if (match[W_HELP] || match[W_QUERY]) begin
            cmd = CODE_HELP;
        end else begin
            cmd = CODE_UNKNOWN;
        end
    end

    // ------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (flush) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((r_rd_idx == r_len) && !r_dv) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // a blank line leaves at once; otherwise wait for the result slot
                if (!r_any || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ----------------------------------------------------- FSM outputs
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_SCAN: begin
                rd_en = (r_rd_idx != r_len);
            end
            ST_FINISH: begin
                out_load = r_any && out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign wr_en = s_xfer && !is_tick && !is_term && (r_len < LEN_FULL);

    // --------------------------------------------------------- datapath
    always_comb begin
        n_len     = r_len;
        n_idle    = r_idle;
        n_limit   = r_limit;
        n_hb      = r_hb;
        n_timeout = r_timeout;
        n_rd_idx  = r_rd_idx;
        n_dv      = rd_en;
        n_cut     = r_cut;
        n_any     = r_any;
        n_gap     = r_gap;
        n_pos     = r_pos;
        n_last    = r_last;
        n_ok      = r_ok;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;

        if (i_cfg_wr_en) begin
            n_limit = i_cfg_wr_data;
        end

        // byte and tick handling
        if (s_xfer) begin
            if (is_tick) begin
                n_idle = idle_inc;
            end else begin
                n_idle = '0;
                if (!is_term) begin
                    // overlong line: drop it together with this byte
                    n_len = (r_len < LEN_FULL) ? r_len + 1'b1 : '0;
                end
            end
        end

        if (flush) begin
            n_timeout = is_tick;
            n_rd_idx  = '0;
            n_cut     = 1'b0;
            n_any     = 1'b0;
            n_gap     = 1'b0;
            n_pos     = '0;
            n_last    = '0;
        end

        // scan: one character a cycle through the compare unit
        if (rd_en) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end
        if (r_state == ST_SCAN && r_dv && !r_cut) begin
            if (cmp.zero) begin
                n_cut = 1'b1;
            end else if (cmp.blank) begin
                if (r_any) begin
                    n_gap = 1'b1;
                    n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
                end
            end else begin
                n_any  = 1'b1;
                n_ok   = (r_any ? r_ok : '1) & cmp.hit
                         & {WORD_CNT{!(r_any && r_gap)}};
                n_pos  = (cmp_pos == POS_MAX) ? cmp_pos : cmp_pos + 1'b1;
                n_last = (cmp_pos == POS_MAX) ? cmp_pos : cmp_pos + 1'b1;
            end
        end

        if (r_state == ST_FINISH) begin
            n_len = '0;
        end

        // result register
        if (out_load) begin
            n_m_valid = 1'b1;
            n_hb      = match[W_AT] ? !r_hb : r_hb;
            n_m_data  = {r_timeout, (match[W_AT] ? !r_hb : r_hb), cmd};
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    // -------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_idle    <= '0;
            r_limit   <= IDLE_LIMIT_RST;
            r_hb      <= 1'b1;
            r_dv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_idle    <= n_idle;
            r_limit   <= n_limit;
            r_hb      <= n_hb;
            r_dv      <= n_dv;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_timeout <= n_timeout;
        r_rd_idx  <= n_rd_idx;
        r_cut     <= n_cut;
        r_any     <= n_any;
        r_gap     <= n_gap;
        r_pos     <= n_pos;
        r_last    <= n_last;
        r_ok      <= n_ok;
        r_m_data  <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_m_data};

endmodule
`default_nettype wire

### src/ccl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccl_checker
// Port-level checks of the command line recogniser, bound to the top level.
// ----------------------------------------------------------------------------
module ccl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic [0:0] s_axis_tuser,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    import ccl_pkg::*;

    // result empty straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stored character never starts a dispatch
    a_byte_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]
         && s_axis_tdata != CH_CR && s_axis_tdata != CH_LF) |=> s_axis_tready)
        else $error("input stalled after a plain character");

    // a new result only comes out of a dispatch
    a_rise_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without dispatch");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

bind console_command_line_recognizer_core ccl_checker u_ccl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console command line recogniser testbench
// Streams received bytes and millisecond ticks into the core. A scoreboard
// tracks the line buffer, idle count and heartbeat, and predicts every
// dispatch. Each result transfer is then checked field by field against the
// oldest prediction. Both stream sides idle and stall at random. The idle
// limit is rewritten between phases, and only once the core has drained.
// ----------------------------------------------------------------------------
module testbench;
    import ccl_pkg::*;

    localparam int LINE_CAPACITY = 96;
    localparam int LINE_MAX      = LINE_CAPACITY - 1;   // characters held before discard
    localparam int SETTLE_CYCLES = LINE_CAPACITY + 16;  // longest scan plus margin
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 20;
    localparam int HOLD_CYCLES   = 400;

    // Line shapes for the random part
    localparam int K_CMD   = 0;
    localparam int K_NEAR  = 1;
    localparam int K_BYTES = 2;
    localparam int K_BLANK = 3;
    localparam int K_ZERO  = 4;
    localparam int K_LONG  = 5;
    localparam int K_PRINT = 6;

    // Same layout as m_axis_tdata, from the top bit down
    typedef struct packed {
        logic [3:0] pad;
        logic       tmo;
        logic       hb;
        logic [1:0] cmd;
    } t_dispatch;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the line buffer, idle count and heartbeat flag,
    // queues each predicted dispatch, and checks result transfers in order.
    // ------------------------------------------------------------------------
    class line_scoreboard;
        logic [7:0] line_buf [LINE_MAX];
        int         line_len;
        logic [9:0] idle_cnt;
        logic       hb_flag;
        logic [9:0] idle_limit;
        t_dispatch  expected_q [$];
        int         errors;

        function new();
            line_len      = 0;
            idle_cnt      = '0;
            hb_flag       = 1'b1;
            idle_limit    = IDLE_LIMIT_RST;
            errors        = 0;
        endfunction

        function logic [7:0] upcase(logic [7:0] c);
            if (c >= 8'h61 && c <= 8'h7A) begin
                return c - 8'h20;
            end
            return c;
        endfunction

        function bit is_gap_char(logic [7:0] c);
            return (c == CH_SPACE) || (c == CH_TAB);
        endfunction

        // True when line_buf[s..e) spells w, case folded
        function bit word_at(int s, int e, string w);
            logic [7:0] wc;
            if (e - s != w.len()) begin
                return 1'b0;
            end
            for (int i = 0; i < w.len(); i++) begin
                wc = w[i];
                if (upcase(line_buf[s + i]) != wc) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void dispatch(logic tmo);
            int        e;
            int        s;
            t_dispatch d;
            e = 0;
            while (e < line_len && line_buf[e] != CH_NUL) e++;
            s = 0;
            while (s < e && is_gap_char(line_buf[s])) s++;
            while (e > s && is_gap_char(line_buf[e - 1])) e--;
            line_len = 0;
            if (e == s) begin
                return;     // nothing left after trimming: no result
            end
            d     = '0;
            d.tmo = tmo;
            if (word_at(s, e, "AT")) begin
                hb_flag = ~hb_flag;
                d.cmd   = CODE_AT;
            end else if (word_at(s, e, "CHECK")) begin
                d.cmd = CODE_CHECK;
            end else if (word_at(s, e, "HELP") || word_at(s, e, "?")) begin
                d.cmd = CODE_HELP;
            end else begin
                d.cmd = CODE_UNKNOWN;
            end
            d.hb = hb_flag;
            expected_q.push_back(d);
        endfunction

        // One accepted input transfer
        function void note_item(logic is_tick, logic [7:0] ch);
            if (!is_tick) begin
                idle_cnt = '0;
                if (ch == CH_CR || ch == CH_LF) begin
                    if (line_len > 0) begin
                        dispatch(1'b0);
                    end
                end else if (line_len < LINE_MAX) begin
                    line_buf[line_len] = ch;
                    line_len++;
                end else begin
                    line_len = 0;   // overlong: line and this byte both dropped
                end
            end else begin
                if (idle_cnt < IDLE_MAX) begin
                    idle_cnt++;
                end
                if (line_len > 0 && idle_cnt >= idle_limit) begin
                    dispatch(1'b1);
                end
            end
        endfunction

        // One accepted result transfer
        function void check_dispatch(logic [7:0] data);
            t_dispatch got;
            t_dispatch want;
            got = data;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.cmd != want.cmd) begin
                $display("%0t: command mismatch, expected %0d, got %0d",
                         $time, want.cmd, got.cmd);
                errors++;
            end
            if (got.hb != want.hb) begin
                $display("%0t: heartbeat_on mismatch, expected %0b, got %0b",
                         $time, want.hb, got.hb);
                errors++;
            end
            if (got.tmo != want.tmo) begin
                $display("%0t: by_timeout mismatch, expected %0b, got %0b",
                         $time, want.tmo, got.tmo);
                errors++;
            end
            if (got.pad != want.pad) begin
                $display("%0t: padding mismatch, expected %h, got %h",
                         $time, want.pad, got.pad);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [9:0] i_cfg_wr_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] rx_byte
    logic [0:0] s_axis_tuser;   // [0] func (0 byte, 1 tick)
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [1:0] command, [2] heartbeat_on, [3] by_timeout, [7:4] zero

    console_command_line_recognizer_core #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    line_scoreboard sb;
    logic [7:0]     line_txt [$];   // line being built for the next send
    bit             tx_eager;       // sender runs without gaps for this line
    bit             hold_req;       // asks the receiver for its long hold-off
    int             items_sent;

    // 4 ns period
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop should the core hang
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Mostly back to back, sometimes short gaps, rarely a long one
    function automatic int tx_gap();
        int r;
        if (tx_eager) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // Drive at the falling edge, hold until a rising edge sees tready
    task automatic send_item(input logic is_tick, input logic [7:0] ch);
        int gap;
        gap = tx_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= is_tick;
        s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(is_tick, ch);
        items_sent++;
    endtask

    // Tick data is don't-care, so toggle it at random
    task automatic send_ticks(input int n);
        repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Optional stray ticks scattered between the characters
    task automatic send_text(input bit noisy);
        foreach (line_txt[i]) begin
            if (noisy && $urandom_range(0, 19) == 0) begin
                send_ticks(1);
            end
            send_item(1'b0, line_txt[i]);
        end
        line_txt.delete();
    endtask

    task automatic send_line(input logic [7:0] term);
        send_text(1'b0);
        send_item(1'b0, term);
    endtask

    function automatic void push_word(string w, bit mixed);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++) begin
            c = w[i];
            if (mixed && c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) begin
                c = c + 8'h20;
            end
            line_txt.push_back(c);
        end
    endfunction

    function automatic void push_pad(int n);
        repeat (n) line_txt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic string pick_word();
        case ($urandom_range(0, 3))
            0:       return "AT";
            1:       return "CHECK";
            2:       return "HELP";
            default: return "?";
        endcase
    endfunction

    function automatic int pick_kind();
        int r;
        r = $urandom_range(0, 23);
        if (r < 12) return K_CMD;
        if (r < 15) return K_NEAR;
        if (r < 17) return K_BYTES;
        if (r < 18) return K_BLANK;
        if (r < 20) return K_ZERO;
        if (r < 21) return K_LONG;
        return K_PRINT;
    endfunction

    // Build one line of the given shape, send it and end it somehow
    task automatic random_line(input int kind);
        string w;
        int    n;
        int    r;
        case (kind)
            K_CMD: begin
                push_pad($urandom_range(0, 2));
                push_word(pick_word(), 1'b1);
                push_pad($urandom_range(0, 2));
            end
            K_NEAR: begin
                w = pick_word();
                case ($urandom_range(0, 3))
                    0: begin            // trailing junk letter
                        push_word(w, 1'b1);
                        line_txt.push_back(8'h41 + 8'($urandom_range(0, 25)));
                    end
                    1: push_word({w, w}, 1'b1);
                    2: begin            // one character swapped
                        push_word(w, 1'b1);
                        line_txt[$urandom_range(0, line_txt.size() - 1)] =
                            8'h41 + 8'($urandom_range(0, 25));
                    end
                    default: begin      // gap inside the word
                        push_word(w.substr(0, 0), 1'b1);
                        push_pad(1);
                        push_word(w.substr(1, w.len() - 1), 1'b1);
                    end
                endcase
            end
            K_BYTES: begin
                n = $urandom_range(1, 12);
                repeat (n) line_txt.push_back(8'($urandom_range(0, 255)));
            end
            K_BLANK: push_pad($urandom_range(0, 4));
            K_ZERO: begin
                if ($urandom_range(0, 1) == 1) begin
                    push_word(pick_word(), 1'b1);
                    line_txt.push_back(CH_NUL);
                    repeat ($urandom_range(0, 4)) line_txt.push_back(8'($urandom_range(1, 255)));
                end else begin
                    push_pad($urandom_range(0, 2));
                    line_txt.push_back(CH_NUL);
                    push_word(pick_word(), 1'b1);
                end
            end
            K_LONG: begin
                // Around the buffer limit: one short, exactly full, one over, a few over
                n = $urandom_range(LINE_MAX - 1, LINE_MAX + 3);
                repeat (n) line_txt.push_back(8'($urandom_range(8'h21, 8'h7E)));
                if ($urandom_range(0, 1) == 1) begin
                    push_word(pick_word(), 1'b1);
                end
            end
            default: begin
                n = $urandom_range(1, 20);
                repeat (n) line_txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
        endcase
        send_text(1'b1);

        r = $urandom_range(0, 9);
        if (r < 6) begin
            send_item(1'b0, $urandom_range(0, 1) ? CH_CR : CH_LF);
        end else if (r < 8 && sb.idle_limit <= 40) begin
            send_ticks(int'(sb.idle_limit) + $urandom_range(0, 2));
        end else if (r == 8 && sb.idle_limit > 1 && sb.idle_limit <= 40) begin
            // Ticks that fall short of the limit, then a terminator
            send_ticks($urandom_range(1, int'(sb.idle_limit) - 1));
            send_item(1'b0, CH_CR);
        end else begin
            // CR LF pair: the LF lands on an empty line
            send_item(1'b0, CH_CR);
            send_item(1'b0, CH_LF);
        end
    endtask

    task automatic run_phase(input int quota);
        int first;
        first = items_sent;
        while (items_sent - first < quota) begin
            tx_eager = ($urandom_range(0, 4) == 0);
            random_line(pick_kind());
        end
        tx_eager = 1'b0;
    endtask

    // Stop offering, let every predicted result out, then allow for a
    // trailing scan of a line that produces nothing
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_idle_limit(input logic [9:0] v);
        settle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        sb.idle_limit = v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: alternates between eager and choppy stretches. Once, a
    // long hold-off backs the core up so that its input stalls too.
    // ------------------------------------------------------------------------
    initial begin
        int   stall_left;
        int   hold_left;
        int   mode_left;
        bit   choppy;
        bit   hold_done;
        logic rdy;
        stall_left = 0;
        hold_left  = 0;
        mode_left  = 0;
        choppy     = 1'b0;
        hold_done  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                choppy    = ($urandom_range(0, 2) != 0);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (choppy && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(0, 2);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_axis_tready <= rdy;
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_dispatch(m_axis_tdata);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        items_sent    = 0;
        tx_eager      = 1'b0;
        hold_req      = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines at the reset idle limit
        push_word("at", 1'b0);
        send_line(CH_CR);                       // AT, heartbeat goes off
        line_txt.push_back(CH_SPACE);
        push_word("Check", 1'b0);
        line_txt.push_back(CH_TAB);
        send_line(CH_LF);                       // trimmed both ends
        push_word("help", 1'b0);
        send_line(CH_CR);
        push_word("?", 1'b0);
        send_line(CH_LF);
        send_item(1'b0, CH_CR);                 // terminator on empty line
        push_word(" \t ", 1'b0);
        send_line(CH_CR);                       // blank line
        push_word("AT", 1'b0);
        line_txt.push_back(CH_NUL);
        push_word("x", 1'b0);
        send_line(CH_CR);                       // zero byte cuts the tail
        line_txt.push_back(CH_TAB);
        line_txt.push_back(CH_NUL);
        push_word("AT", 1'b0);
        send_line(CH_LF);                       // blank before the zero
        line_txt.push_back(8'hFF);
        line_txt.push_back(CH_NUL);
        send_line(CH_CR);                       // top byte value, unknown
        push_word("ATX", 1'b0);
        send_line(CH_LF);
        push_word("hElP", 1'b0);
        send_text(1'b0);
        send_ticks(int'(IDLE_LIMIT_RST));       // idle timeout dispatch

        random_line(K_LONG);

        // Receiver holds off while short commands keep coming
        hold_req = 1'b1;
        tx_eager = 1'b1;
        push_word("at", 1'b0);
        send_line(CH_CR);
        push_word("?", 1'b0);
        send_line(CH_LF);
        push_word("check", 1'b0);
        send_line(CH_CR);
        push_word("help", 1'b0);
        send_line(CH_LF);
        tx_eager = 1'b0;

        // Smallest limits: timeouts follow a byte almost at once
        write_idle_limit(10'd1);
        run_phase(PHASE_ITEMS);
        write_idle_limit(10'd0);
        push_word("at", 1'b0);
        send_text(1'b0);
        send_ticks(1);
        run_phase(PHASE_ITEMS);

        // Largest limit: lines only end by terminators
        write_idle_limit(10'd1023);
        run_phase(PHASE_ITEMS);

        write_idle_limit(10'd4);
        run_phase(PHASE_ITEMS);
        write_idle_limit(10'd37);
        run_phase(PHASE_ITEMS);

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
src/ccl_pkg.sv
src/ccl_line_mem.sv
src/ccl_cmp_unit.sv
src/console_command_line_recognizer_core.sv
src/ccl_checker.sv
tb/testbench.sv
